>>> hdl/sn7seg_pkg.sv
// Shared constants and the digit segment table for the seven-segment line encoder.
package sn7seg_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned MAG_W   = 14;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned SEG_W   = 8;
  localparam int unsigned DECS_W  = 2;
  localparam int unsigned NUM_DIGITS = 4;

  localparam logic signed [VALUE_W-1:0] CLAMP_MAX = 32'sd9999;
  localparam logic signed [VALUE_W-1:0] CLAMP_MIN = -32'sd9999;

  localparam logic [SEG_W-1:0] SEG_MINUS = 8'h40;
  localparam logic [SEG_W-1:0] SEG_POINT = 8'h10;
  localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;

  // Reciprocal constants for quotients of a 14-bit magnitude.
  localparam logic [15:0] RECIP_10   = 16'd52429;
  localparam int unsigned SHIFT_10   = 19;
  localparam logic [15:0] RECIP_100  = 16'd5243;
  localparam int unsigned SHIFT_100  = 19;
  localparam logic [15:0] RECIP_1000 = 16'd8389;
  localparam int unsigned SHIFT_1000 = 23;

  typedef logic [SEG_W-1:0]   seg_t;
  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [MAG_W-1:0]   mag_t;

  function automatic seg_t digit_seg(input digit_t d);
    seg_t s;
    case (d)
      4'd0:    s = 8'hAF;
      4'd1:    s = 8'hA0;
      4'd2:    s = 8'hCB;
      4'd3:    s = 8'hE9;
      4'd4:    s = 8'hE4;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h6F;
      4'd7:    s = 8'hA8;
      4'd8:    s = 8'hEF;
      4'd9:    s = 8'hED;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

endpackage

>>> hdl/signed_number_to_seven_segment_line_top.sv
// Signed number to segment bytes of one four-digit seven-segment display line.
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------------
//  in      | in_valid / in_stall  | line_select, decimals, value
//  out     | out_valid / out_stall| line_out, seg_digit0..seg_digit3, minus_symbol
//
// One beat in, one beat out, through an input register, then the clamp,
// reciprocal digit split and segment encode, then the result register.
// Throughput is one beat per cycle; the input register refills in the same
// cycle the result register is loaded, so in_stall rises only when the result
// register is full and stalled while the input register also holds a beat.
// Synchronous active-high rst empties both registers; payload is not reset.
module signed_number_to_seven_segment_line_top
  import sn7seg_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      line_select,
  input  logic [DECS_W-1:0]         decimals,
  input  logic signed [VALUE_W-1:0] value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      line_out,
  output logic [SEG_W-1:0]          seg_digit0,
  output logic [SEG_W-1:0]          seg_digit1,
  output logic [SEG_W-1:0]          seg_digit2,
  output logic [SEG_W-1:0]          seg_digit3,
  output logic                      minus_symbol
);

  // Input register.
  logic                      s1_valid;
  logic                      s1_line;
  logic [DECS_W-1:0]         s1_decs;
  logic signed [VALUE_W-1:0] s1_value;

  logic in_take;
  logic s1_adv;

  // The result register can load when it is empty or its beat leaves now.
  assign s1_adv   = !out_valid || !out_stall;
  assign in_stall = s1_valid && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_line  <= line_select;
      s1_decs  <= decimals;
      s1_value <= value;
    end
  end

  // Clamp to +-9999 and take the magnitude.
  logic signed [VALUE_W-1:0] clamped;
  logic                      neg;
  logic [VALUE_W-1:0]        abs_full;
  mag_t                      mag;

  always_comb begin
    if (s1_value > CLAMP_MAX) begin
      clamped = CLAMP_MAX;
    end else if (s1_value < CLAMP_MIN) begin
      clamped = CLAMP_MIN;
    end else begin
      clamped = s1_value;
    end
    neg      = clamped[VALUE_W-1];
    abs_full = neg ? VALUE_W'(-clamped) : VALUE_W'(clamped);
    mag      = abs_full[MAG_W-1:0];
  end

  // Decimal split: three independent reciprocal quotients, then subtract
  // ten times the next coarser quotient to get each digit below the thousands.
  logic [MAG_W+15:0] prod_10;
  logic [MAG_W+15:0] prod_100;
  logic [MAG_W+15:0] prod_1000;
  logic [9:0]        quot_10;
  logic [6:0]        quot_100;
  logic [3:0]        quot_1000;
  digit_t            dig [NUM_DIGITS];

  always_comb begin
    prod_10   = (MAG_W+16)'(mag) * (MAG_W+16)'(RECIP_10);
    prod_100  = (MAG_W+16)'(mag) * (MAG_W+16)'(RECIP_100);
    prod_1000 = (MAG_W+16)'(mag) * (MAG_W+16)'(RECIP_1000);
    quot_10   = prod_10[SHIFT_10 +: 10];
    quot_100  = prod_100[SHIFT_100 +: 7];
    quot_1000 = prod_1000[SHIFT_1000 +: 4];
    dig[0] = quot_1000;
    dig[1] = DIGIT_W'(quot_100 - 7'(quot_1000) * 7'd10);
    dig[2] = DIGIT_W'(quot_10  - 10'(quot_100) * 10'd10);
    dig[3] = DIGIT_W'(mag      - MAG_W'(quot_10) * MAG_W'(10));
  end

  // Blanking, minus placement and decimal point over the four digits.
  seg_t seg_next [NUM_DIGITS];
  logic minus_next;

  always_comb begin
    logic shown;
    logic neg_left;
    logic forced;
    shown      = 1'b0;
    neg_left   = neg;
    minus_next = 1'b0;
    for (int k = 0; k < NUM_DIGITS; k++) begin
      seg_next[k] = SEG_BLANK;
    end
    if (s1_decs != '0) begin
      seg_next[2'(3 - int'(s1_decs))] = SEG_POINT;
    end
    for (int k = 0; k < NUM_DIGITS; k++) begin
      forced = (k == NUM_DIGITS - 1) || (int'(s1_decs) >= (NUM_DIGITS - 1 - k));
      if ((dig[k] != '0) || shown || forced) begin
        // Drop the minus on the blank digit to the left, or on the symbol.
        if (neg_left) begin
          if (k == 0) begin
            minus_next = 1'b1;
          end else begin
            seg_next[k-1] = seg_next[k-1] | SEG_MINUS;
          end
          neg_left = 1'b0;
        end
        seg_next[k] = seg_next[k] | digit_seg(dig[k]);
        shown = 1'b1;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      line_out     <= s1_line;
      seg_digit0   <= seg_next[0];
      seg_digit1   <= seg_next[1];
      seg_digit2   <= seg_next[2];
      seg_digit3   <= seg_next[3];
      minus_symbol <= minus_next;
    end
  end

  // The rightmost digit is always lit.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (seg_digit3 != SEG_BLANK))
    else $error("rightmost digit blank");

  // The minus symbol only goes with a shown leftmost digit.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && minus_symbol) |-> (seg_digit0 != SEG_BLANK))
    else $error("minus symbol without leftmost digit");

  // A stalled input beat means the input register holds one next cycle.
  assert property (@(posedge clk) disable iff (rst)
    in_stall |=> s1_valid)
    else $error("input register lost a beat");

  // A result leaves only when it was taken.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped while stalled");

endmodule

>>> dv/tb.sv
// Self-checking testbench for the signed number to seven-segment line encoder.
module tb;
  import sn7seg_pkg::*;

  // Hold-off length for the backpressure test, and the watchdog limit on
  // cycles without any beat. The limit covers the hold-off plus the longest
  // sender gap several times over.
  localparam int HOLD_CYCLES  = 80;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PRINT_CAP    = 40;

  // Segment pattern of each decimal digit, 0 through 9.
  localparam seg_t GLYPH [10] = '{8'hAF, 8'hA0, 8'hCB, 8'hE9, 8'hE4,
                                  8'h6D, 8'h6F, 8'hA8, 8'hEF, 8'hED};

  typedef struct {
    logic                      line;
    seg_t                      seg [4];
    logic                      minus;
    logic signed [VALUE_W-1:0] src;
  } seg_line_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      line_select = 1'b0;
  logic [DECS_W-1:0]         decimals = '0;
  logic signed [VALUE_W-1:0] value = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      line_out;
  seg_t                      seg_digit0, seg_digit1, seg_digit2, seg_digit3;
  logic                      minus_symbol;

  seg_line_t expected_lines [$];
  int        mismatches = 0;
  int        idle_cycles = 0;

  // Idle controls, changed by the tests between stretches of beats.
  bit tx_idling = 1'b1;
  bit rx_idling = 1'b1;
  bit hold_req  = 1'b0;

  signed_number_to_seven_segment_line_top uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .line_select  (line_select),
    .decimals     (decimals),
    .value        (value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .line_out     (line_out),
    .seg_digit0   (seg_digit0),
    .seg_digit1   (seg_digit1),
    .seg_digit2   (seg_digit2),
    .seg_digit3   (seg_digit3),
    .minus_symbol (minus_symbol)
  );

  always #5 clk = ~clk;

  // Predict one display line: clamp, split into digits, blank leading zeros
  // unless forced by the decimal count, place the minus left of the first
  // lit digit (or on the separate symbol when all four are lit), OR in the
  // decimal point.
  function automatic seg_line_t predict_line(input logic ln, input logic [1:0] decs,
                                             input logic signed [VALUE_W-1:0] val);
    seg_line_t res;
    int        clamped;
    int        mag;
    int        d;
    int        dig [4];
    bit        neg;
    bit        lit;
    bit        forced;
    res.line  = ln;
    res.minus = 1'b0;
    res.src   = val;
    for (int k = 0; k < 4; k++) res.seg[k] = SEG_BLANK;
    clamped = val;
    if (val > 9999) clamped = 9999;
    else if (val < -9999) clamped = -9999;
    neg = (clamped < 0);
    mag = neg ? -clamped : clamped;
    dig[0] = mag / 1000;
    dig[1] = (mag / 100) % 10;
    dig[2] = (mag / 10) % 10;
    dig[3] = mag % 10;
    d = int'(decs);
    if (d != 0) res.seg[3-d] |= SEG_POINT;
    lit = 1'b0;
    for (int k = 0; k < 4; k++) begin
      forced = (k == 3) || (d >= 3 - k);
      if (dig[k] != 0 || lit || forced) begin
        if (neg) begin
          if (k == 0) res.minus = 1'b1;
          else res.seg[k-1] |= SEG_MINUS;
          neg = 1'b0;
        end
        res.seg[k] |= GLYPH[dig[k]];
        lit = 1'b1;
      end
    end
    return res;
  endfunction

  // Mostly back-to-back, sometimes a short gap, rarely a long gap.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Favor in-range and boundary numbers; keep a share of full 32-bit noise so
  // every bit of the value toggles.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 35) v = int'($urandom_range(0, 19998)) - 9999;
    else if (r < 55) v = int'($urandom_range(0, 198)) - 99;
    else if (r < 67) v = int'($urandom_range(0, 18)) - 9;
    else if (r < 77) begin
      v = int'($urandom_range(9990, 10010));
      if ($urandom_range(0, 1)) v = -v;
    end else v = int'($urandom());
    return v;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want, input logic [31:0] src);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("mismatch %s: got %0h expected %0h (value %0d)", what, got, want,
               $signed(src));
  endtask

  // Offer one beat and hold it until accepted, then queue its prediction.
  // Called right after a rising edge; valid stays high across back-to-back beats.
  task automatic send_number(input logic ln, input logic [1:0] decs,
                             input logic signed [VALUE_W-1:0] val);
    int gap;
    gap = tx_idling ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    line_select <= ln;
    decimals    <= decs;
    value       <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_lines.push_back(predict_line(ln, decs, val));
  endtask

  // Saturation at both ends, including the most positive and negative words.
  task automatic test_clamp();
    send_number(1'b0, 2'd0, 32'sd9999);
    send_number(1'b1, 2'd0, 32'sd10000);
    send_number(1'b0, 2'd1, 32'sh7FFFFFFF);
    send_number(1'b1, 2'd0, -32'sd9999);
    send_number(1'b0, 2'd2, -32'sd10000);
    send_number(1'b1, 2'd3, 32'sh80000000);
  endtask

  // Zero never shows a minus; each decimal count forces its leading zeros.
  task automatic test_zero_and_unit();
    for (int d = 0; d < 4; d++) send_number(d[0], d[1:0], 32'sd0);
    send_number(1'b0, 2'd0, -32'sd1);
    send_number(1'b1, 2'd3, 32'sd1);
  endtask

  // Minus placement against the decimal point: on a blank digit, or on the
  // separate symbol when all four digits are lit.
  task automatic test_sign_and_point();
    send_number(1'b0, 2'd1, -32'sd5);
    send_number(1'b1, 2'd2, -32'sd5);
    send_number(1'b0, 2'd3, -32'sd5);
    send_number(1'b1, 2'd0, -32'sd123);
    send_number(1'b0, 2'd0, -32'sd1234);
    send_number(1'b1, 2'd1, -32'sd12);
    send_number(1'b0, 2'd2, 32'sd1234);
    send_number(1'b1, 2'd3, -32'sd9999);
  endtask

  // Hold the output off long enough that both pipeline registers fill and the
  // input stalls, while the sender keeps offering beats.
  task automatic test_backpressure();
    tx_idling = 1'b0;
    rx_idling = 1'b0;
    hold_req  = 1'b1;
    for (int i = 0; i < 16; i++)
      send_number(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), pick_value());
  endtask

  // Random beats in chunks, each chunk with its own idle pattern so some
  // stretches run with no gaps on either side.
  task automatic test_random(input int count);
    int left;
    left = count;
    while (left > 0) begin
      tx_idling = $urandom_range(0, 1);
      rx_idling = $urandom_range(0, 1);
      for (int i = 0; i < 100 && left > 0; i++) begin
        send_number(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), pick_value());
        left--;
      end
    end
  endtask

  // Receiver: random stalls, or one long hold-off when a test requests it.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (rx_idling) stall_left = pick_gap();
      end
    end
  end

  // Compare each result beat against the oldest prediction, field by field.
  always @(posedge clk) begin : check_results
    seg_line_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_lines.size() == 0) begin
        report_mismatch("unexpected beat", {31'd0, line_out}, 32'd0, 32'd0);
      end else begin
        want = expected_lines.pop_front();
        if (line_out !== want.line)
          report_mismatch("line_out", 32'(line_out), 32'(want.line), want.src);
        if (seg_digit0 !== want.seg[0])
          report_mismatch("seg_digit0", 32'(seg_digit0), 32'(want.seg[0]), want.src);
        if (seg_digit1 !== want.seg[1])
          report_mismatch("seg_digit1", 32'(seg_digit1), 32'(want.seg[1]), want.src);
        if (seg_digit2 !== want.seg[2])
          report_mismatch("seg_digit2", 32'(seg_digit2), 32'(want.seg[2]), want.src);
        if (seg_digit3 !== want.seg[3])
          report_mismatch("seg_digit3", 32'(seg_digit3), 32'(want.seg[3]), want.src);
        if (minus_symbol !== want.minus)
          report_mismatch("minus_symbol", 32'(minus_symbol), 32'(want.minus), want.src);
      end
    end
  end

  // Watchdog: end the run if no beat moves on either side for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_clamp();
    test_zero_and_unit();
    test_sign_and_point();
    test_backpressure();
    test_random(1400);
    in_valid <= 1'b0;
    // Drain: wait for every prediction to be matched, then watch for strays.
    while (expected_lines.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

>>> sim.f
hdl/sn7seg_pkg.sv
hdl/signed_number_to_seven_segment_line_top.sv
dv/tb.sv
